>>> src/charge_phase_adapter_assert.svh
// Assertion macros for the charge phase adapter RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef CHARGE_PHASE_ADAPTER_ASSERT_SVH
`define CHARGE_PHASE_ADAPTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("charge_phase_adapter check failed");

// Next-cycle implication, disabled during reset.
`define CPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("charge_phase_adapter check failed");

`endif

>>> src/cpa_pkg.sv
// Shared types and codes for the charge phase adapter.
// No dependencies; imported by cpa_rule, charge_phase_adapter and the testbench.
package cpa_pkg;

    localparam logic [2:0] PH_UNKNOWN  = 3'd0;
    localparam logic [2:0] PH_CHARGING = 3'd1;
    localparam logic [2:0] PH_FULL     = 3'd2;
    localparam logic [2:0] PH_CLOSED   = 3'd3;
    localparam logic [2:0] PH_FAULT    = 3'd4;

    localparam logic [2:0] EV_START   = 3'd0;
    localparam logic [2:0] EV_CLOSE   = 3'd1;
    localparam logic [2:0] EV_FULL    = 3'd2;
    localparam logic [2:0] EV_KEEP    = 3'd3;
    localparam logic [2:0] EV_IN      = 3'd4;
    localparam logic [2:0] EV_OFF     = 3'd5;
    localparam logic [2:0] EV_UNSUP   = 3'd6;
    localparam logic [2:0] EV_INVALID = 3'd7;

    localparam logic [2:0] ST_ERROR    = 3'd0;
    localparam logic [2:0] ST_PENDING  = 3'd1;
    localparam logic [2:0] ST_NOCHANGE = 3'd2;
    localparam logic [2:0] ST_UPDATED  = 3'd3;
    localparam logic [2:0] ST_FAULTREC = 3'd4;

    localparam logic [1:0] OP_EVENT  = 2'd0;
    localparam logic [1:0] OP_RETRY  = 2'd1;
    localparam logic [1:0] OP_STRONG = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    localparam logic [7:0] RAW_ZERO = 8'd0;
    localparam logic [7:0] RAW_ONE  = 8'd1;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] ev;
        logic [7:0] raw;
        logic       emit_ok;
        logic       pub_ok;
    } t_item;

    typedef struct packed {
        logic       snap_on;
        logic [2:0] snap_ph;
        logic       pend_on;
        logic [2:0] pend_ph;
        logic       has_pend;
        logic       term_fail;
    } t_state;

    typedef struct packed {
        logic       pend_flag;
        logic [2:0] com_ph;
        logic       com_on;
        logic [2:0] off_ph;
        logic       off_on;
        logic       pub_iss;
        logic       cmd_code;
        logic       cmd_iss;
        logic [2:0] status;
    } t_res;

endpackage

>>> src/cpa_rule.sv
// Combinational rule of the charge phase adapter: one item against the state.
// Depends on cpa_pkg.
module cpa_rule
    import cpa_pkg::*;
(
    input  t_item  i_item,
    input  t_state i_state,
    output t_state o_state,
    output t_res   o_res
);

    logic       raw_ok;
    logic       r1;
    logic       agree;
    logic       latched;
    logic       broken;
    logic       con;
    logic [2:0] cph;
    logic       has_cmd;
    logic       code;
    t_state     ns;
    t_res       res;

    always_comb begin
        raw_ok  = (i_item.raw == RAW_ZERO) || (i_item.raw == RAW_ONE);
        r1      = (i_item.raw == RAW_ONE);
        latched = (i_state.snap_ph == PH_FULL) || (i_state.snap_ph == PH_FAULT);
        broken  = i_state.has_pend && i_state.term_fail;

        case (i_item.ev)
            EV_START, EV_FULL, EV_KEEP, EV_IN: agree = raw_ok && r1;
            EV_OFF:                            agree = raw_ok && !r1;
            EV_CLOSE, EV_UNSUP:                agree = raw_ok;
            default:                           agree = 1'b0;
        endcase

        con = i_state.snap_on;
        cph = i_state.snap_ph;
        if (!raw_ok) begin
            cph = PH_FAULT;
        end else if (!agree) begin
            con = r1;
            cph = PH_FAULT;
        end else begin
            case (i_item.ev)
                EV_IN: begin
                    con = 1'b1;
                end
                EV_START: begin
                    con = 1'b1;
                    if (!latched) cph = PH_CHARGING;
                end
                EV_FULL: begin
                    con = 1'b1;
                    if (!(i_state.snap_on && i_state.snap_ph == PH_FAULT)) cph = PH_FULL;
                end
                EV_CLOSE: begin
                    con = r1;
                    if (!latched) cph = PH_CLOSED;
                end
                EV_OFF: begin
                    con = 1'b0;
                    cph = PH_CLOSED;
                end
                default: begin
                    con = r1;
                    cph = PH_FAULT;
                end
            endcase
        end

        has_cmd = 1'b0;
        code    = CMD_START;
        if (!agree) begin
            has_cmd = 1'b1;
            code    = CMD_CLOSE;
        end else if (i_item.ev == EV_IN && !i_state.snap_on && !latched) begin
            has_cmd = 1'b1;
            code    = CMD_START;
        end else if (i_item.ev == EV_FULL && !latched) begin
            has_cmd = 1'b1;
            code    = CMD_CLOSE;
        end else if (i_item.ev == EV_OFF || i_item.ev == EV_KEEP || i_item.ev == EV_UNSUP) begin
            has_cmd = 1'b1;
            code    = CMD_CLOSE;
        end

        ns          = i_state;
        res         = '0;
        res.status  = ST_ERROR;

        case (i_item.op)
            OP_EVENT: begin
                if (broken || i_item.ev == EV_INVALID || i_state.term_fail) begin
                    res.status = ST_ERROR;
                end else if (i_state.has_pend) begin
                    res.status = ST_PENDING;
                end else if (con == i_state.snap_on && cph == i_state.snap_ph) begin
                    res.status = ST_NOCHANGE;
                end else begin
                    res.cmd_iss  = has_cmd;
                    res.cmd_code = has_cmd & code;
                    if (has_cmd && !i_item.emit_ok) begin
                        ns.pend_on  = con;
                        ns.pend_ph  = (code == CMD_CLOSE) ? cph : PH_FAULT;
                        ns.has_pend = 1'b1;
                        res.status  = ST_PENDING;
                    end else begin
                        res.pub_iss = 1'b1;
                        res.off_on  = con;
                        res.off_ph  = cph;
                        if (!i_item.pub_ok) begin
                            if (has_cmd && code == CMD_CLOSE) begin
                                ns.term_fail = 1'b1;
                                res.status   = ST_ERROR;
                            end else begin
                                ns.pend_on  = con;
                                ns.pend_ph  = PH_FAULT;
                                ns.has_pend = 1'b1;
                                res.status  = ST_PENDING;
                            end
                        end else begin
                            ns.snap_on = con;
                            ns.snap_ph = cph;
                            res.status = ST_UPDATED;
                        end
                    end
                end
            end
            OP_RETRY: begin
                if (broken || i_state.term_fail) begin
                    res.status = ST_ERROR;
                end else if (!i_state.has_pend) begin
                    res.status = ST_NOCHANGE;
                end else begin
                    res.cmd_iss  = 1'b1;
                    res.cmd_code = CMD_CLOSE;
                    if (!i_item.emit_ok) begin
                        res.status = ST_PENDING;
                    end else begin
                        res.pub_iss = 1'b1;
                        res.off_on  = i_state.pend_on;
                        res.off_ph  = i_state.pend_ph;
                        ns.has_pend = 1'b0;
                        if (!i_item.pub_ok) begin
                            ns.term_fail = 1'b1;
                            res.status   = ST_ERROR;
                        end else begin
                            ns.snap_on = i_state.pend_on;
                            ns.snap_ph = i_state.pend_ph;
                            res.status = ST_UPDATED;
                        end
                    end
                end
            end
            OP_STRONG: begin
                if (broken || i_state.term_fail || !i_state.has_pend || !raw_ok) begin
                    res.status = ST_ERROR;
                end else begin
                    ns.pend_on  = r1;
                    ns.pend_ph  = PH_FAULT;
                    ns.has_pend = 1'b1;
                    res.status  = ST_FAULTREC;
                end
            end
            default: begin
                res.status = broken ? ST_ERROR : ST_NOCHANGE;
            end
        endcase

        res.com_on    = ns.snap_on;
        res.com_ph    = ns.snap_ph;
        res.pend_flag = ns.has_pend;
    end

    assign o_state = ns;
    assign o_res   = res;

endmodule

>>> src/charge_phase_adapter.sv
// Top level of the charge phase adapter: input register, rule logic, result register.
// Depends on cpa_pkg, cpa_rule and charge_phase_adapter_assert.svh.
//
//   channel  | dir | tdata (low bit up)                                  | tuser
//   s_axis   | in  | event_kind[2:0] online_raw[10:3] emit_ok[11]         | operation[1:0]
//            |     | publish_ok[12], zero pad [15:13]                    |
//   m_axis   | out | status[2:0] command_issued[3] command_code[4]       | -
//            |     | publish_issued[5] offered_online[6] offered_phase   |
//            |     | [9:7] committed_online[10] committed_phase[13:11]   |
//            |     | pending_close_flag[14], zero pad [15]               |
//
// One item per cycle sustained while the output accepts; input, then result register.
// The rule evaluates the input register against the snapshot state combinationally.
// Synchronous active-low reset clears both stage valids and all snapshot state.
// A stalled output holds both stages; input ready stays high while a stage is free.
`include "charge_phase_adapter_assert.svh"

module charge_phase_adapter
    import cpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // event_kind, online_raw, emit_ok, publish_ok
    input  logic [1:0]  i_s_axis_tuser,  // operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata   // status, command_issued, command_code,
                                         // publish_issued, offered_online,
                                         // offered_phase, committed_online,
                                         // committed_phase, pending_close_flag
);

    logic   r_in_valid;
    t_item  r_item;
    logic   r_out_valid;
    t_res   r_res;
    t_state r_state;
    t_state n_state;
    t_res   n_res;
    t_item  w_item;
    logic   w_adv;
    logic   w_take;

    assign w_item.op      = i_s_axis_tuser;
    assign w_item.ev      = i_s_axis_tdata[2:0];
    assign w_item.raw     = i_s_axis_tdata[10:3];
    assign w_item.emit_ok = i_s_axis_tdata[11];
    assign w_item.pub_ok  = i_s_axis_tdata[12];

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    cpa_rule u_rule (
        .i_item  (r_item),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= w_item;
        end
        if (w_adv && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_res};

    `CPA_ASSERT_NOW(a_no_pend_with_fail, i_clk, i_rst_n, r_state.has_pend, !r_state.term_fail)
    `CPA_ASSERT_NEXT(a_fail_sticky, i_clk, i_rst_n, r_state.term_fail, r_state.term_fail)
    `CPA_ASSERT_NEXT(a_state_only_on_step, i_clk, i_rst_n, !(w_adv && r_in_valid), $stable(r_state))
    `CPA_ASSERT_NOW(a_code_needs_cmd, i_clk, i_rst_n, r_out_valid && r_res.cmd_code, r_res.cmd_iss)
    `CPA_ASSERT_NOW(a_offer_zero, i_clk, i_rst_n, r_out_valid && !r_res.pub_iss, r_res.off_ph == PH_UNKNOWN && !r_res.off_on)

endmodule

>>> tb/charge_phase_adapter_checker.sv
// Scoreboard for the charge phase adapter: predicts one result per input transfer
// and compares each output transfer field by field. Depends on cpa_pkg.
module charge_phase_adapter_checker
    import cpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_in_data,
    input  logic [1:0]  i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,
    output int          o_fail_count,
    output int          o_waiting,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic       snap_on;
    logic [2:0] snap_ph;
    logic       pend_on;
    logic [2:0] pend_ph;
    logic       has_pend;
    logic       term_fail;

    t_res   expected_results[$];
    t_item  item_in;
    t_res   want;
    t_res   got;
    int     mismatches = 0;
    int     checked = 0;

    function automatic logic is_latched(logic [2:0] ph);
        return ph == PH_FULL || ph == PH_FAULT;
    endfunction

    function automatic logic raw_in_range(logic [7:0] raw);
        return raw == RAW_ZERO || raw == RAW_ONE;
    endfunction

    function automatic logic raw_agrees(logic [2:0] ev, logic [7:0] raw);
        if (!raw_in_range(raw)) return 1'b0;
        case (ev)
            EV_START, EV_FULL, EV_KEEP, EV_IN: return raw == RAW_ONE;
            EV_OFF:                            return raw == RAW_ZERO;
            EV_CLOSE, EV_UNSUP:                return 1'b1;
            default:                           return 1'b0;
        endcase
    endfunction

    function automatic t_res predict_result(t_item it);
        t_res       res;
        logic       broken;
        logic       r1;
        logic       cand_on;
        logic [2:0] cand_ph;
        logic       has_cmd;
        logic       code;
        res = '0;
        res.status = ST_ERROR;
        broken = has_pend && term_fail;
        r1 = it.raw == RAW_ONE;
        case (it.op)
            OP_EVENT: begin
                if (broken || it.ev == EV_INVALID || term_fail) begin
                    res.status = ST_ERROR;
                end else if (has_pend) begin
                    res.status = ST_PENDING;
                end else begin
                    cand_on = snap_on;
                    cand_ph = snap_ph;
                    if (!raw_in_range(it.raw)) begin
                        cand_ph = PH_FAULT;
                    end else if (!raw_agrees(it.ev, it.raw)) begin
                        cand_on = r1;
                        cand_ph = PH_FAULT;
                    end else begin
                        case (it.ev)
                            EV_IN: cand_on = 1'b1;
                            EV_START: begin
                                cand_on = 1'b1;
                                if (!is_latched(snap_ph)) cand_ph = PH_CHARGING;
                            end
                            EV_FULL: begin
                                cand_on = 1'b1;
                                if (!(snap_on && snap_ph == PH_FAULT)) cand_ph = PH_FULL;
                            end
                            EV_CLOSE: begin
                                cand_on = r1;
                                if (!is_latched(snap_ph)) cand_ph = PH_CLOSED;
                            end
                            EV_OFF: begin
                                cand_on = 1'b0;
                                cand_ph = PH_CLOSED;
                            end
                            default: begin
                                cand_on = r1;
                                cand_ph = PH_FAULT;
                            end
                        endcase
                    end
                    if (cand_on == snap_on && cand_ph == snap_ph) begin
                        res.status = ST_NOCHANGE;
                    end else begin
                        code = CMD_CLOSE;
                        if (!raw_agrees(it.ev, it.raw)) begin
                            has_cmd = 1'b1;
                        end else if (it.ev == EV_IN && !snap_on && !is_latched(snap_ph)) begin
                            has_cmd = 1'b1;
                            code = CMD_START;
                        end else begin
                            has_cmd = (it.ev == EV_FULL && !is_latched(snap_ph))
                                   || it.ev == EV_OFF || it.ev == EV_KEEP
                                   || it.ev == EV_UNSUP;
                        end
                        res.cmd_iss = has_cmd;
                        res.cmd_code = has_cmd & code;
                        if (has_cmd && !it.emit_ok) begin
                            pend_on = cand_on;
                            pend_ph = (code == CMD_CLOSE) ? cand_ph : PH_FAULT;
                            has_pend = 1'b1;
                            res.status = ST_PENDING;
                        end else begin
                            res.pub_iss = 1'b1;
                            res.off_on = cand_on;
                            res.off_ph = cand_ph;
                            if (!it.pub_ok) begin
                                if (has_cmd && code == CMD_CLOSE) begin
                                    term_fail = 1'b1;
                                    res.status = ST_ERROR;
                                end else begin
                                    pend_on = cand_on;
                                    pend_ph = PH_FAULT;
                                    has_pend = 1'b1;
                                    res.status = ST_PENDING;
                                end
                            end else begin
                                snap_on = cand_on;
                                snap_ph = cand_ph;
                                res.status = ST_UPDATED;
                            end
                        end
                    end
                end
            end
            OP_RETRY: begin
                if (broken || term_fail) begin
                    res.status = ST_ERROR;
                end else if (!has_pend) begin
                    res.status = ST_NOCHANGE;
                end else begin
                    res.cmd_iss = 1'b1;
                    res.cmd_code = CMD_CLOSE;
                    if (!it.emit_ok) begin
                        res.status = ST_PENDING;
                    end else begin
                        res.pub_iss = 1'b1;
                        res.off_on = pend_on;
                        res.off_ph = pend_ph;
                        has_pend = 1'b0;
                        if (!it.pub_ok) begin
                            term_fail = 1'b1;
                            res.status = ST_ERROR;
                        end else begin
                            snap_on = pend_on;
                            snap_ph = pend_ph;
                            res.status = ST_UPDATED;
                        end
                    end
                end
            end
            OP_STRONG: begin
                if (broken || term_fail || !has_pend || !raw_in_range(it.raw)) begin
                    res.status = ST_ERROR;
                end else begin
                    pend_on = r1;
                    pend_ph = PH_FAULT;
                    res.status = ST_FAULTREC;
                end
            end
            default: res.status = broken ? ST_ERROR : ST_NOCHANGE;
        endcase
        res.com_on = snap_on;
        res.com_ph = snap_ph;
        res.pend_flag = has_pend;
        return res;
    endfunction

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            snap_on = 1'b0;
            snap_ph = PH_UNKNOWN;
            pend_on = 1'b0;
            pend_ph = PH_UNKNOWN;
            has_pend = 1'b0;
            term_fail = 1'b0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = t_res'(i_out_data[14:0]);
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    check_field("status", int'(want.status), int'(got.status));
                    check_field("command_issued", int'(want.cmd_iss), int'(got.cmd_iss));
                    check_field("command_code", int'(want.cmd_code), int'(got.cmd_code));
                    check_field("publish_issued", int'(want.pub_iss), int'(got.pub_iss));
                    check_field("offered_online", int'(want.off_on), int'(got.off_on));
                    check_field("offered_phase", int'(want.off_ph), int'(got.off_ph));
                    check_field("committed_online", int'(want.com_on), int'(got.com_on));
                    check_field("committed_phase", int'(want.com_ph), int'(got.com_ph));
                    check_field("pending_close_flag", int'(want.pend_flag),
                                int'(got.pend_flag));
                end
            end
            if (i_in_valid && i_in_ready) begin
                item_in.op = i_in_user;
                item_in.ev = i_in_data[2:0];
                item_in.raw = i_in_data[10:3];
                item_in.emit_ok = i_in_data[11];
                item_in.pub_ok = i_in_data[12];
                expected_results.push_back(predict_result(item_in));
            end
        end
        o_fail_count <= mismatches;
        o_waiting <= expected_results.size();
        o_checked <= checked;
    end

endmodule

>>> tb/charge_phase_adapter_tb.sv
// Testbench top for the charge phase adapter: clock, reset, stimulus and verdict.
// Depends on cpa_pkg, charge_phase_adapter and charge_phase_adapter_checker.
module charge_phase_adapter_tb;
    import cpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;  // event_kind, online_raw, emit_ok, publish_ok
    logic [1:0]  s_tuser = '0;  // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;       // status .. pending_close_flag

    int fail_count;
    int waiting;
    int checked;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_cycles = 0;
    int sent_by_op[4] = '{0, 0, 0, 0};

    charge_phase_adapter i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    charge_phase_adapter_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_data    (s_tdata),
        .i_in_user    (s_tuser),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_checked    (checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("charge_phase_adapter test failed");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] op, logic [2:0] ev, logic [7:0] raw,
                             logic emit_ok, logic pub_ok);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, pub_ok, emit_ok, raw, ev};
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_by_op[op]++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
    endtask

    // Unless allowed, a refused publish comes only with a refused or no command, so
    // the sticky terminal error stays out of reach and the state space stays open.
    task automatic send_random(bit allow_terminal);
        logic [1:0] op;
        logic [2:0] ev;
        logic [7:0] raw;
        logic       emit_ok;
        logic       pub_ok;
        int         pick;
        pick = $urandom_range(99);
        op = (pick < 55) ? OP_EVENT : (pick < 75) ? OP_RETRY :
             (pick < 88) ? OP_STRONG : OP_READ;
        ev = ($urandom_range(19) == 0) ? EV_INVALID : 3'($urandom_range(6));
        pick = $urandom_range(99);
        raw = (pick < 45) ? RAW_ZERO : (pick < 88) ? RAW_ONE :
              (pick < 94) ? 8'hFF : 8'($urandom_range(255, 2));
        emit_ok = ($urandom_range(99) < 70);
        pub_ok = ($urandom_range(99) < 80);
        if (!allow_terminal && !pub_ok && (op == OP_EVENT || op == OP_RETRY)
            && !(op == OP_EVENT && ((ev == EV_START && raw == RAW_ONE)
                                    || (ev == EV_CLOSE && raw <= RAW_ONE))))
            emit_ok = 1'b0;
        send_item(op, ev, raw, emit_ok, pub_ok);
        if ($urandom_range(199) == 0) drain_results();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 22;
        rx_idle_pct = 85;

        send_item(OP_READ,   EV_INVALID, 8'hFF,    1'b1, 1'b1);
        send_item(OP_RETRY,  EV_START,   RAW_ZERO, 1'b1, 1'b1);
        send_item(OP_STRONG, EV_START,   RAW_ONE,  1'b1, 1'b1);
        send_item(OP_EVENT,  EV_INVALID, RAW_ZERO, 1'b1, 1'b1);
        send_item(OP_EVENT,  EV_IN,      RAW_ONE,  1'b1, 1'b1);
        send_item(OP_EVENT,  EV_START,   RAW_ONE,  1'b1, 1'b1);
        send_item(OP_EVENT,  EV_KEEP,    RAW_ONE,  1'b1, 1'b1);
        send_item(OP_EVENT,  EV_START,   RAW_ONE,  1'b1, 1'b1);
        send_item(OP_EVENT,  EV_FULL,    RAW_ONE,  1'b1, 1'b1);
        send_item(OP_EVENT,  EV_OFF,     RAW_ZERO, 1'b1, 1'b1);
        send_item(OP_EVENT,  EV_IN,      8'hFF,    1'b1, 1'b1);
        send_item(OP_EVENT,  EV_CLOSE,   RAW_ZERO, 1'b1, 1'b1);
        send_item(OP_EVENT,  EV_FULL,    RAW_ONE,  1'b1, 1'b0);
        send_item(OP_EVENT,  EV_IN,      RAW_ONE,  1'b1, 1'b1);
        send_item(OP_RETRY,  EV_START,   RAW_ZERO, 1'b0, 1'b0);
        send_item(OP_STRONG, EV_START,   8'hFF,    1'b1, 1'b1);
        send_item(OP_STRONG, EV_START,   RAW_ZERO, 1'b1, 1'b1);
        send_item(OP_RETRY,  EV_START,   RAW_ZERO, 1'b1, 1'b1);
        send_item(OP_EVENT,  EV_UNSUP,   RAW_ONE,  1'b1, 1'b1);
        send_item(OP_EVENT,  EV_START,   RAW_ZERO, 1'b1, 1'b1);
        send_item(OP_EVENT,  EV_CLOSE,   RAW_ONE,  1'b0, 1'b0);
        send_item(OP_RETRY,  EV_START,   RAW_ZERO, 1'b1, 1'b1);
        send_item(OP_READ,   EV_START,   RAW_ZERO, 1'b0, 1'b0);
        drain_results();

        repeat (440) send_random(1'b0);
        drain_results();
        tx_idle_pct = 85;
        rx_idle_pct = 22;
        repeat (440) send_random(1'b0);
        drain_results();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (390) send_random(1'b0);
        repeat (60) send_random(1'b1);

        // force the sticky terminal error, then show it blocks all but reads
        send_item(OP_RETRY,  EV_START, RAW_ZERO, 1'b1, 1'b1);
        send_item(OP_EVENT,  EV_START, RAW_ZERO, 1'b1, 1'b0);
        send_item(OP_EVENT,  EV_KEEP,  RAW_ONE,  1'b1, 1'b0);
        send_item(OP_EVENT,  EV_IN,    RAW_ONE,  1'b1, 1'b1);
        send_item(OP_RETRY,  EV_START, RAW_ONE,  1'b1, 1'b1);
        send_item(OP_STRONG, EV_START, RAW_ONE,  1'b1, 1'b1);
        send_item(OP_READ,   EV_START, RAW_ONE,  1'b1, 1'b1);

        drain_results();
        repeat (10) @(posedge clk);
        $display("Covered %0d event, %0d retry, %0d strengthen and %0d read transfers;",
                 sent_by_op[OP_EVENT], sent_by_op[OP_RETRY], sent_by_op[OP_STRONG],
                 sent_by_op[OP_READ]);
        $display("%0d results checked under three idle mixes, ending in terminal error.",
                 checked);
        if (fail_count == 0 && waiting == 0) begin
            $display("charge_phase_adapter test passed");
        end else begin
            $display("charge_phase_adapter test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/cpa_pkg.sv
src/cpa_rule.sv
src/charge_phase_adapter.sv
tb/charge_phase_adapter_checker.sv
tb/charge_phase_adapter_tb.sv
